[sv/thm_pkg.sv]
// thm_pkg: shared constants, codes and state type of the heatmap accumulator
// no dependencies; imported by thm_div, thm_mem and time_binned_heatmap_accumulator
package thm_pkg;

  // parameter defaults
  localparam int unsigned THM_MAX_BINS  = 1024;
  localparam int unsigned THM_NUM_CHIPS = 32;
  localparam int unsigned THM_TIME_BITS = 32;

  // field and register widths
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned COUNT_W    = 11;
  localparam int unsigned MASK_W     = 32;
  localparam int unsigned INCR_W     = 8;
  localparam int unsigned OP_W       = 2;
  localparam int unsigned CHIP_W     = 5;
  localparam int unsigned IDX_W      = 10;
  localparam int unsigned VALUE_W    = 8;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // register reset values
  localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd1024;
  localparam logic [MASK_W-1:0]  MASK_RESET  = '1;

  // operation codes
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
  localparam logic [OP_W-1:0] OP_EVENT = 2'd1;
  localparam logic [OP_W-1:0] OP_READ  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_START = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_END   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MASK  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INCR  = 3'd4;

  localparam logic [VALUE_W-1:0] INCR_DEFAULT = 8'd32;
  localparam logic [VALUE_W-1:0] VALUE_MAX    = 8'd255;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL,
    ST_DIV_GO,
    ST_DIV,
    ST_RMW_RD,
    ST_RMW_WR,
    ST_READ,
    ST_RESP
  } state_e;

  function automatic logic [VALUE_W-1:0] sat_add(input logic [VALUE_W-1:0] a,
                                                 input logic [VALUE_W-1:0] b);
    logic [VALUE_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[VALUE_W] ? VALUE_MAX : sum[VALUE_W-1:0];
  endfunction

endpackage

[sv/thm_div.sv]
// thm_div: restoring divider, one quotient bit per cycle through one shared subtractor
// depends on thm_pkg for default widths
module thm_div import thm_pkg::*; #(
  parameter int unsigned NUM_W = THM_TIME_BITS + 11,
  parameter int unsigned DEN_W = THM_TIME_BITS,
  parameter int unsigned QUO_W = 10
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] numer_i,
  input  logic [DEN_W-1:0] denom_i,
  output logic             busy_o,
  output logic [QUO_W-1:0] quot_o
);

  localparam int unsigned CNT_W = $clog2(QUO_W + 1);

  logic [CNT_W-1:0] cnt_q;
  logic [DEN_W-1:0] rem_q;
  logic [DEN_W-1:0] den_q;
  logic [QUO_W-1:0] quo_q;

  logic [DEN_W:0]   shifted;
  logic [DEN_W+1:0] sub;
  logic             ge;
  logic [QUO_W:0]   quo_sh;
  logic [NUM_W-1:0] numer_hi;

  // quotient is known to fit in QUO_W bits, so the upper part starts below the divisor
  assign numer_hi = numer_i >> QUO_W;
  assign shifted  = {rem_q, quo_q[QUO_W-1]};
  assign sub      = {1'b0, shifted} - {2'b00, den_q};
  assign ge       = ~sub[DEN_W+1];
  assign quo_sh   = {quo_q, ge};

  assign busy_o = (cnt_q != '0);
  assign quot_o = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= CNT_W'(QUO_W);
    end else if (busy_o) begin
      cnt_q <= cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= numer_hi[DEN_W-1:0];
      quo_q <= numer_i[QUO_W-1:0];
      den_q <= denom_i;
    end else if (busy_o) begin
      rem_q <= ge ? sub[DEN_W-1:0] : shifted[DEN_W-1:0];
      quo_q <= quo_sh[QUO_W-1:0];
    end
  end

endmodule

[sv/thm_mem.sv]
// thm_mem: bin storage, one write port and one registered read port
// depends on thm_pkg for default depth and data width
module thm_mem import thm_pkg::*; #(
  parameter int unsigned DEPTH = THM_MAX_BINS,
  parameter int unsigned AW    = 10
) (
  input  logic               clk_i,
  input  logic               we_i,
  input  logic [AW-1:0]      waddr_i,
  input  logic [VALUE_W-1:0] wdata_i,
  input  logic               re_i,
  input  logic [AW-1:0]      raddr_i,
  output logic [VALUE_W-1:0] rdata_o
);

  logic [VALUE_W-1:0] bin_mem [DEPTH];
  logic [VALUE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      bin_mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= bin_mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[sv/time_binned_heatmap_accumulator.sv]
// Time-binned heatmap accumulator: bins events of a time window into saturating 8-bit counters.
// An event request passes through acceptance, a multiply, the divider start, the shared
// restoring divider and then a read-modify-write of the bin memory; a dropped or ignored
// command and an unused code are taken while idle and leave the block idle; a read request
// passes through a bin memory read and a response step that waits out any output stall; a
// clear request, like reset, makes the block sweep all MAX_BINS bins to zero before it takes
// its next request. The divider loop and the bin memory, with one write port and one read
// port, set these steps.
// Configuration writes belong in gaps where no request is in flight.
module time_binned_heatmap_accumulator import thm_pkg::*; #(
  parameter int unsigned MAX_BINS  = THM_MAX_BINS,
  parameter int unsigned NUM_CHIPS = THM_NUM_CHIPS,
  parameter int unsigned TIME_BITS = THM_TIME_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [OP_W-1:0]       operation_i,
  input  logic [TIME_W-1:0]     event_time_i,
  input  logic [CHIP_W-1:0]     chip_id_i,
  input  logic [IDX_W-1:0]      read_index_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [IDX_W-1:0]      bin_number_o,
  output logic [VALUE_W-1:0]    bin_value_o
);

  localparam int unsigned TW = (TIME_BITS < TIME_W) ? TIME_BITS : TIME_W;
  localparam int unsigned AW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam int unsigned NW = $clog2(MAX_BINS + 1);
  localparam int unsigned PW = TW + NW;

  // configuration
  logic [TIME_W-1:0]  start_q, end_q;
  logic [COUNT_W-1:0] bin_count_q;
  logic [MASK_W-1:0]  chip_mask_q;
  logic [INCR_W-1:0]  incr_q;

  // control
  state_e        state_q, state_d;
  logic [AW-1:0] clr_cnt_q, clr_cnt_d;
  logic          past_end_q, past_end_d;
  logic          out_valid_q;

  // payload
  logic [TW-1:0]      diff_q, span_q;
  logic [NW-1:0]      n_q;
  logic [PW-1:0]      product_q;
  logic [IDX_W-1:0]   rd_idx_q;
  logic [IDX_W-1:0]   bin_number_q;
  logic [VALUE_W-1:0] bin_value_q;

  logic [TW-1:0]      ev_t, win_s, win_e;
  logic [NW-1:0]      n_eff, n_m1;
  logic               chip_ok, load_cmd, load_read, out_load, div_start, div_busy;
  logic [AW-1:0]      div_quot, bin_sel, rd_addr;
  logic [AW+IDX_W-1:0] idx_wide;
  logic               rd_in_range;
  logic               mem_we, mem_re;
  logic [AW-1:0]      mem_waddr, mem_raddr;
  logic [VALUE_W-1:0] mem_wdata, mem_rdata, incr_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q     <= '0;
      end_q       <= '0;
      bin_count_q <= COUNT_RESET;
      chip_mask_q <= MASK_RESET;
      incr_q      <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_START: start_q     <= cfg_data_i[TIME_W-1:0];
        CFG_END:   end_q       <= cfg_data_i[TIME_W-1:0];
        CFG_COUNT: bin_count_q <= cfg_data_i[COUNT_W-1:0];
        CFG_MASK:  chip_mask_q <= cfg_data_i[MASK_W-1:0];
        CFG_INCR:  incr_q      <= cfg_data_i[INCR_W-1:0];
        default: ;
      endcase
    end
  end

  assign ev_t  = event_time_i[TW-1:0];
  assign win_s = start_q[TW-1:0];
  assign win_e = end_q[TW-1:0];

  // bin counts above the memory depth act as the depth
  always_comb begin
    if (32'(bin_count_q) > MAX_BINS) begin
      n_eff = NW'(MAX_BINS);
    end else begin
      n_eff = NW'(bin_count_q);
    end
  end

  assign chip_ok = (32'(chip_id_i) < NUM_CHIPS) && chip_mask_q[chip_id_i];

  // quotient never exceeds n-1 for a time inside the window; clamp to the last bin otherwise
  assign n_m1    = n_q - NW'(1);
  assign bin_sel = (32'(div_quot) >= 32'(n_q)) ? n_m1[AW-1:0] : div_quot;

  assign idx_wide    = (AW + IDX_W)'(rd_idx_q);
  assign rd_addr     = idx_wide[AW-1:0];
  assign rd_in_range = 32'(rd_idx_q) < MAX_BINS;

  assign incr_eff  = (incr_q == '0) ? INCR_DEFAULT : incr_q;

  always_comb begin
    state_d    = state_q;
    clr_cnt_d  = clr_cnt_q;
    past_end_d = past_end_q;
    in_stall_o = 1'b1;
    mem_we     = 1'b0;
    mem_waddr  = clr_cnt_q;
    mem_wdata  = '0;
    mem_re     = 1'b0;
    mem_raddr  = bin_sel;
    div_start  = 1'b0;
    load_cmd   = 1'b0;
    load_read  = 1'b0;
    out_load   = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        mem_we = 1'b1;
        if (clr_cnt_q == AW'(MAX_BINS - 1)) begin
          state_d = ST_IDLE;
        end else begin
          clr_cnt_d = clr_cnt_q + AW'(1);
        end
      end
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          unique case (operation_i)
            OP_CLEAR: begin
              past_end_d = 1'b0;
              clr_cnt_d  = '0;
              state_d    = ST_CLEAR;
            end
            OP_EVENT: begin
              if (!past_end_q && (n_eff != '0) && (win_s < win_e) && (ev_t >= win_s)) begin
                // past-end wins over the chip filter
                if (ev_t >= win_e) begin
                  past_end_d = 1'b1;
                end else if (chip_ok) begin
                  load_cmd = 1'b1;
                  state_d  = ST_MUL;
                end
              end
            end
            OP_READ: begin
              load_read = 1'b1;
              state_d   = ST_READ;
            end
            default: ;
          endcase
        end
      end
      ST_MUL:    state_d = ST_DIV_GO;
      ST_DIV_GO: begin
        div_start = 1'b1;
        state_d   = ST_DIV;
      end
      ST_DIV: begin
        if (!div_busy) begin
          state_d = ST_RMW_RD;
        end
      end
      ST_RMW_RD: begin
        mem_re  = 1'b1;
        state_d = ST_RMW_WR;
      end
      ST_RMW_WR: begin
        mem_we    = 1'b1;
        mem_waddr = bin_sel;
        mem_wdata = sat_add(mem_rdata, incr_eff);
        state_d   = ST_IDLE;
      end
      ST_READ: begin
        mem_re    = 1'b1;
        mem_raddr = rd_addr;
        state_d   = ST_RESP;
      end
      ST_RESP: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      past_end_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      clr_cnt_q  <= clr_cnt_d;
      past_end_q <= past_end_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_cmd) begin
      diff_q <= ev_t - win_s;
      span_q <= win_e - win_s;
      n_q    <= n_eff;
    end
    if (state_q == ST_MUL) begin
      product_q <= PW'(diff_q) * PW'(n_q);
    end
    if (load_read) begin
      rd_idx_q <= read_index_i;
    end
    if (out_load) begin
      bin_number_q <= rd_idx_q;
      bin_value_q  <= rd_in_range ? mem_rdata : '0;
    end
  end

  thm_div #(
    .NUM_W (PW),
    .DEN_W (TW),
    .QUO_W (AW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .numer_i (product_q),
    .denom_i (span_q),
    .busy_o  (div_busy),
    .quot_o  (div_quot)
  );

  thm_mem #(
    .DEPTH (MAX_BINS),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign out_valid_o  = out_valid_q;
  assign bin_number_o = bin_number_q;
  assign bin_value_o  = bin_value_q;

  // bin memory is only written by the sweep or the read-modify-write
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == ST_CLEAR || state_q == ST_RMW_WR))
    else $error("bin write outside sweep or update");

  // updated bin stays inside the bins in use
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RMW_WR) |-> (32'(bin_sel) < 32'(n_q)))
    else $error("bin index beyond bin count");

  // past-end flag only rises on a request taken while idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(past_end_q) |-> ($past(state_q) == ST_IDLE && $past(in_valid_i)))
    else $error("past-end set without a command request");

  // divider is quiet whenever the block can take a request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !div_busy)
    else $error("divider busy while idle");

endmodule
